// ===== rtl/core/fdd_pkg.sv =====
// shared types, widths and status codes of the finite difference derivative block
package fdd_pkg;

    // sample and slope width, fixed by the payload fields
    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;
    localparam logic [1:0] ST_SHORT = 2'd3;

    // input beat
    typedef struct packed {
        logic signed [DATA_W-1:0] position;
        logic signed [DATA_W-1:0] value;
        logic                     final_point;
    } sample_t;

    // result beat
    typedef struct packed {
        logic signed [DATA_W-1:0] slope;
        logic [1:0]               status;
        logic                     end_of_run;
    } result_t;

    // divider control from the sequencer
    typedef struct packed {
        logic start;
        logic take;
    } div_ctrl_t;

endpackage

// ===== rtl/core/fdd_div.sv =====
// bit-serial signed fixed-point divider with zero check and saturation
module fdd_div
    import fdd_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  div_ctrl_t                ctrl,
    input  logic signed [DATA_W+2:0] num,
    input  logic signed [DATA_W+1:0] den,
    output logic                     res_valid,
    output logic signed [DATA_W-1:0] res_slope,
    output logic [1:0]               res_status
);

    // magnitude, dividend and compare widths
    localparam int MW    = DATA_W + 2;
    localparam int DVW   = MW + FRACTION_BITS;
    localparam int TW    = DVW - DATA_W;
    localparam int CW    = (TW > MW) ? TW : MW;
    localparam int CNT_W = $clog2(DATA_W);

    localparam logic [CNT_W-1:0]  LAST_BIT  = CNT_W'(DATA_W - 1);
    localparam logic [DATA_W-1:0] SLOPE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] SLOPE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum logic [5:0] {
        D_IDLE  = 6'b000001,
        D_ABS   = 6'b000010,
        D_CHECK = 6'b000100,
        D_SHIFT = 6'b001000,
        D_ROUND = 6'b010000,
        D_HOLD  = 6'b100000
    } div_state_t;

    div_state_t               state_reg, state_next;
    logic signed [DATA_W+2:0] num_reg, num_next;
    logic signed [DATA_W+1:0] den_reg, den_next;
    logic                     neg_reg, neg_next;
    logic [MW-1:0]            num_mag_reg, num_mag_next;
    logic [MW-1:0]            den_mag_reg, den_mag_next;
    logic [MW-1:0]            rem_reg, rem_next;
    logic [DATA_W-1:0]        quo_reg, quo_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [DATA_W-1:0]        slope_reg, slope_next;
    logic [1:0]               status_reg, status_next;

    logic [DVW-1:0]           dividend;
    logic [CW-1:0]            top_ext;
    logic [CW-1:0]            den_ext;
    logic [MW:0]              trial;
    logic [MW:0]              diff;
    logic                     fits;

    // numerator magnitude scaled by the fraction bits; top part decides overflow up front
    assign dividend = DVW'(num_mag_reg) << FRACTION_BITS;
    assign top_ext  = CW'(dividend[DVW-1:DATA_W]);
    assign den_ext  = CW'(den_mag_reg);

    // one restoring step per cycle
    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, den_mag_reg};
    assign fits  = trial >= {1'b0, den_mag_reg};

    // sequencing of one division
    always_comb begin
        state_next   = state_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        neg_next     = neg_reg;
        num_mag_next = num_mag_reg;
        den_mag_next = den_mag_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        slope_next   = slope_reg;
        status_next  = status_reg;
        case (state_reg)
            D_IDLE: begin
                if (ctrl.start) begin
                    num_next   = num;
                    den_next   = den;
                    state_next = D_ABS;
                end
            end
            D_ABS: begin
                neg_next     = num_reg[DATA_W+2] ^ den_reg[DATA_W+1];
                num_mag_next = num_reg[DATA_W+2] ? MW'(-num_reg) : MW'(num_reg);
                den_mag_next = den_reg[DATA_W+1] ? MW'(-den_reg) : MW'(den_reg);
                state_next   = D_CHECK;
            end
            D_CHECK: begin
                if (den_mag_reg == '0) begin
                    slope_next  = '0;
                    status_next = ST_ZERO;
                    state_next  = D_HOLD;
                end else if (top_ext >= den_ext) begin
                    slope_next  = neg_reg ? SLOPE_MIN : SLOPE_MAX;
                    status_next = ST_SAT;
                    state_next  = D_HOLD;
                end else begin
                    rem_next   = top_ext[MW-1:0];
                    quo_next   = dividend[DATA_W-1:0];
                    cnt_next   = LAST_BIT;
                    state_next = D_SHIFT;
                end
            end
            D_SHIFT: begin
                rem_next = fits ? diff[MW-1:0] : trial[MW-1:0];
                quo_next = {quo_reg[DATA_W-2:0], fits};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = D_ROUND;
                end
            end
            D_ROUND: begin
                state_next  = D_HOLD;
                status_next = ST_OK;
                if (neg_reg) begin
                    if (quo_reg > SLOPE_MIN) begin
                        slope_next  = SLOPE_MIN;
                        status_next = ST_SAT;
                    end else begin
                        slope_next = -quo_reg;
                    end
                end else begin
                    if (quo_reg[DATA_W-1]) begin
                        slope_next  = SLOPE_MAX;
                        status_next = ST_SAT;
                    end else begin
                        slope_next = quo_reg;
                    end
                end
            end
            D_HOLD: begin
                if (ctrl.take) begin
                    state_next = D_IDLE;
                end
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        num_reg     <= num_next;
        den_reg     <= den_next;
        neg_reg     <= neg_next;
        num_mag_reg <= num_mag_next;
        den_mag_reg <= den_mag_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        slope_reg   <= slope_next;
        status_reg  <= status_next;
    end

    assign res_valid  = (state_reg == D_HOLD);
    assign res_slope  = slope_reg;
    assign res_status = status_reg;

`ifndef SYNTH
    // a new division only starts on an idle unit
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> state_reg == D_IDLE)
        else $error("divider started while busy");

    // zero spacing always reports a zero slope
    a_zero_slope: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_status == ST_ZERO) |-> res_slope == '0)
        else $error("zero spacing with nonzero slope");

    // last quotient bit leads straight to rounding
    a_shift_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == D_SHIFT && cnt_reg == '0) |=> state_reg == D_ROUND)
        else $error("divider missed end of shift");
`endif

endmodule

// ===== rtl/core/finite_difference_derivative.sv =====
// top level: three point finite difference derivative over a stream of samples
// slopes come one sample behind the input; a sample yields zero to three slopes
// each slope is formed by the bit-serial divider, which retires one quotient bit per cycle;
// zero spacing or early overflow skips the shift steps and goes straight to the result;
// the next sample is taken once all slopes are queued
// aresetn (synchronous, active low) clears the sequence count and all handshake state
module finite_difference_derivative
    import fdd_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  sample_t s_payload,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_payload
);

    // job slots within one sample
    localparam int JOB_FWD  = 0;
    localparam int JOB_CENT = 1;
    localparam int JOB_BACK = 2;

    typedef enum logic [5:0] {
        T_IDLE  = 6'b000001,
        T_NEXT  = 6'b000010,
        T_FORM  = 6'b000100,
        T_MERGE = 6'b001000,
        T_WAIT  = 6'b010000,
        T_SHORT = 6'b100000
    } top_state_t;

    top_state_t               state_reg, state_next;
    logic [1:0]               points_seen_reg, points_seen_next;
    logic [2:0]               jobs_reg, jobs_next;
    logic [2:0]               job_reg, job_next;
    logic                     short_reg, short_next;
    logic                     last_reg, last_next;
    logic                     shift_hist;
    logic signed [DATA_W-1:0] older_pos_reg, older_val_reg;
    logic signed [DATA_W-1:0] prior_pos_reg, prior_val_reg;
    logic signed [DATA_W-1:0] cur_pos_reg, cur_pos_next;
    logic signed [DATA_W-1:0] cur_val_reg, cur_val_next;
    logic signed [DATA_W:0]   a_reg, a_next;
    logic signed [DATA_W:0]   e_reg, e_next;
    logic signed [DATA_W:0]   dd_reg, dd_next;
    logic                     m_valid_reg, m_valid_next;
    result_t                  m_payload_reg, m_payload_next;

    logic signed [DATA_W:0]   xo_x, xp_x, xc_x, fo_x, fp_x, fc_x;
    logic signed [DATA_W+2:0] a4, e3, div_num;
    logic signed [DATA_W+1:0] div_den;
    logic                     fwd_sel;
    logic                     out_free;
    div_ctrl_t                div_ctrl;
    logic                     div_res_valid;
    logic signed [DATA_W-1:0] div_res_slope;
    logic [1:0]               div_res_status;

    // sign-extended history for the differences
    assign xo_x = {older_pos_reg[DATA_W-1], older_pos_reg};
    assign xp_x = {prior_pos_reg[DATA_W-1], prior_pos_reg};
    assign xc_x = {cur_pos_reg[DATA_W-1], cur_pos_reg};
    assign fo_x = {older_val_reg[DATA_W-1], older_val_reg};
    assign fp_x = {prior_val_reg[DATA_W-1], prior_val_reg};
    assign fc_x = {cur_val_reg[DATA_W-1], cur_val_reg};

    // stencil numerators: forward 4(fp-fo)-(fc-fo), backward 4(fc-fp)-(fc-fo)
    assign fwd_sel = jobs_reg[JOB_FWD];
    assign a4      = {a_reg, 2'b00};
    assign e3      = {{2{e_reg[DATA_W]}}, e_reg};
    assign div_num = job_reg[JOB_CENT] ? e3 : a4 - e3;
    assign div_den = {dd_reg, 1'b0};

    assign out_free = !m_valid_reg || m_ready;

    // sample sequencer
    always_comb begin
        state_next       = state_reg;
        points_seen_next = points_seen_reg;
        jobs_next        = jobs_reg;
        job_next         = job_reg;
        short_next       = short_reg;
        last_next        = last_reg;
        cur_pos_next     = cur_pos_reg;
        cur_val_next     = cur_val_reg;
        a_next           = a_reg;
        e_next           = e_reg;
        dd_next          = dd_reg;
        shift_hist       = 1'b0;
        div_ctrl.start   = 1'b0;
        div_ctrl.take    = 1'b0;
        m_valid_next     = m_valid_reg && !m_ready;
        m_payload_next   = m_payload_reg;
        case (state_reg)
            T_IDLE: begin
                if (s_valid) begin
                    cur_pos_next       = s_payload.position;
                    cur_val_next       = s_payload.value;
                    last_next          = s_payload.final_point;
                    jobs_next[JOB_FWD]  = (points_seen_reg == 2'd2);
                    jobs_next[JOB_CENT] = points_seen_reg[1];
                    jobs_next[JOB_BACK] = points_seen_reg[1] && s_payload.final_point;
                    short_next         = !points_seen_reg[1] && s_payload.final_point;
                    if (s_payload.final_point) begin
                        points_seen_next = 2'd0;
                    end else if (points_seen_reg != 2'd3) begin
                        points_seen_next = points_seen_reg + 2'd1;
                    end
                    state_next = T_NEXT;
                end
            end
            T_NEXT: begin
                if (short_reg) begin
                    state_next = T_SHORT;
                end else if (jobs_reg != '0) begin
                    state_next = T_FORM;
                end else begin
                    shift_hist = !last_reg;
                    state_next = T_IDLE;
                end
            end
            T_FORM: begin
                job_next           = '0;
                job_next[JOB_FWD]  = fwd_sel;
                job_next[JOB_CENT] = !fwd_sel && jobs_reg[JOB_CENT];
                job_next[JOB_BACK] = !fwd_sel && !jobs_reg[JOB_CENT];
                a_next     = fwd_sel ? fp_x - fo_x : fc_x - fp_x;
                e_next     = fc_x - fo_x;
                dd_next    = fwd_sel ? xp_x - xo_x : xc_x - xp_x;
                state_next = T_MERGE;
            end
            T_MERGE: begin
                div_ctrl.start = 1'b1;
                state_next     = T_WAIT;
            end
            T_WAIT: begin
                if (div_res_valid && out_free) begin
                    div_ctrl.take             = 1'b1;
                    m_valid_next              = 1'b1;
                    m_payload_next.slope      = div_res_slope;
                    m_payload_next.status     = div_res_status;
                    m_payload_next.end_of_run = job_reg[JOB_BACK];
                    jobs_next                 = jobs_reg & ~job_reg;
                    state_next                = T_NEXT;
                end
            end
            T_SHORT: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_payload_next.slope      = '0;
                    m_payload_next.status     = ST_SHORT;
                    m_payload_next.end_of_run = 1'b1;
                    short_next                = 1'b0;
                    state_next                = T_NEXT;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= T_IDLE;
            points_seen_reg <= 2'd0;
            jobs_reg        <= '0;
            short_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            points_seen_reg <= points_seen_next;
            jobs_reg        <= jobs_next;
            short_reg       <= short_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // sample history and working operands
    always_ff @(posedge aclk) begin
        job_reg       <= job_next;
        last_reg      <= last_next;
        cur_pos_reg   <= cur_pos_next;
        cur_val_reg   <= cur_val_next;
        a_reg         <= a_next;
        e_reg         <= e_next;
        dd_reg        <= dd_next;
        m_payload_reg <= m_payload_next;
        if (shift_hist) begin
            older_pos_reg <= prior_pos_reg;
            older_val_reg <= prior_val_reg;
            prior_pos_reg <= cur_pos_reg;
            prior_val_reg <= cur_val_reg;
        end
    end

    // shared serial divider
    fdd_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (div_ctrl),
        .num        (div_num),
        .den        (div_den),
        .res_valid  (div_res_valid),
        .res_slope  (div_res_slope),
        .res_status (div_res_status)
    );

    assign s_ready   = (state_reg == T_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTH
    // nothing left over from the previous sample when a new one is taken
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_IDLE) |-> (jobs_reg == '0 && !short_reg))
        else $error("pending work while accepting");

    // a final beat among the first two samples gives only the short result
    a_short_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_payload.final_point && !points_seen_reg[1])
        |=> (short_reg && jobs_reg == '0))
        else $error("short sequence not flagged");

    // exactly one stencil is in flight while waiting on the divider
    a_one_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_WAIT) |-> $onehot(job_reg))
        else $error("stencil selection not one-hot");

    // a divider result is only taken when one is held
    a_take_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctrl.take |-> div_res_valid)
        else $error("divider result taken while not valid");
`endif

endmodule
